// ===== hw/rtl/obb_sat_pkg.sv =====
// shared widths, payload types and helper functions of the oriented box overlap test
`default_nettype none

package obb_sat_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int AXIS_FRAC_BITS = 14;
  localparam int AXIS_W         = AXIS_FRAC_BITS + 2;
  localparam int HALF_W         = 24;
  localparam int DEPTH_W        = 27;
  localparam int FRAC_DROP      = 2 * AXIS_FRAC_BITS;
  localparam int NUM_AXES       = 4;

  // axis dot products, projections, center distance and overlap widths
  localparam int DOT_W   = 2 * AXIS_W + 1;
  localparam int ADOT_W  = 2 * AXIS_W;
  localparam int PROJ_W  = HALF_W + ADOT_W;
  localparam int RAD_W   = PROJ_W + 2;
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int DPROD_W = DIFF_W + AXIS_W;
  localparam int DN_W    = DPROD_W + 1;
  localparam int DIST_W  = DN_W - 1 + AXIS_FRAC_BITS;
  localparam int OV_W    = ((RAD_W > DIST_W) ? RAD_W : DIST_W) + 1;

  localparam int IN_DATA_W   = 2 * COORD_WIDTH + 2 * HALF_W + 4 * AXIS_W;
  localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 2 * AXIS_W + DEPTH_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TEST = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cz;
    logic        [HALF_W-1:0]      hx;
    logic        [HALF_W-1:0]      hz;
    logic signed [AXIS_W-1:0]      a1x;
    logic signed [AXIS_W-1:0]      a1z;
    logic signed [AXIS_W-1:0]      a2x;
    logic signed [AXIS_W-1:0]      a2z;
  } box_t;

  function automatic logic signed [DOT_W-1:0] dot2(
    input logic signed [AXIS_W-1:0] ux,
    input logic signed [AXIS_W-1:0] uz,
    input logic signed [AXIS_W-1:0] nx,
    input logic signed [AXIS_W-1:0] nz
  );
    logic signed [DOT_W-1:0] px;
    logic signed [DOT_W-1:0] pz;
    px = DOT_W'(ux) * DOT_W'(nx);
    pz = DOT_W'(uz) * DOT_W'(nz);
    return px + pz;
  endfunction

  function automatic logic [ADOT_W-1:0] abs_dot(input logic signed [DOT_W-1:0] v);
    logic signed [DOT_W-1:0] m;
    m = v[DOT_W-1] ? -v : v;
    return m[ADOT_W-1:0];
  endfunction

  function automatic logic [DN_W-2:0] abs_dn(input logic signed [DN_W-1:0] v);
    logic signed [DN_W-1:0] m;
    m = v[DN_W-1] ? -v : v;
    return m[DN_W-2:0];
  endfunction

  // negation that maps the most negative code to the largest one
  function automatic logic signed [AXIS_W-1:0] neg_sat(input logic signed [AXIS_W-1:0] v);
    logic signed [AXIS_W-1:0] r;
    if (v == {1'b1, {(AXIS_W-1){1'b0}}}) begin
      r = {1'b0, {(AXIS_W-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/obb_2d_sat_overlap.sv =====
// a test item's result passes through stages 1 to 7 and is offered from the stage 7 register
// throughput: one item per cycle while the output is not stalled; each of the 7 stages has its
// own valid bit and a ready chain, so bubbles close up while the output is stalled
// load items write the reference box at acceptance and give no result
// reset (rst, synchronous) empties the pipeline and clears the reference box to zero
`default_nettype none

module obb_2d_sat_overlap
  import obb_sat_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // center_x, center_z, half_x, half_z, axis1_x, axis1_z, axis2_x, axis2_z
  input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
  // kind
  input  wire                    s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // normal_x, normal_z, depth
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // hit
  output logic                   m_axis_tuser
);

  localparam int NUM_STAGES = 7;
  localparam int OFF_CZ  = COORD_WIDTH;
  localparam int OFF_HX  = 2 * COORD_WIDTH;
  localparam int OFF_HZ  = OFF_HX + HALF_W;
  localparam int OFF_A1X = OFF_HZ + HALF_W;
  localparam int OFF_A1Z = OFF_A1X + AXIS_W;
  localparam int OFF_A2X = OFF_A1Z + AXIS_W;
  localparam int OFF_A2Z = OFF_A2X + AXIS_W;
  localparam logic [OV_W-1:0]    HALF_LSB  = OV_W'(1) << (FRAC_DROP - 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  logic [NUM_STAGES:1]   v;
  logic [NUM_STAGES+1:1] rdy;
  box_t                  in_box;
  box_t                  ref_box;
  logic                  load_acc;

  box_t s1_a, s1_b;
  logic signed [AXIS_W-1:0] s1_nx [NUM_AXES];
  logic signed [AXIS_W-1:0] s1_nz [NUM_AXES];

  logic [ADOT_W-1:0]        s2_ad1 [NUM_AXES];
  logic [ADOT_W-1:0]        s2_ad2 [NUM_AXES];
  logic [ADOT_W-1:0]        s2_bd1 [NUM_AXES];
  logic [ADOT_W-1:0]        s2_bd2 [NUM_AXES];
  logic signed [DIFF_W-1:0] s2_dx, s2_dz;
  logic [HALF_W-1:0]        s2_hax, s2_haz, s2_hbx, s2_hbz;
  logic signed [AXIS_W-1:0] s2_nx [NUM_AXES];
  logic signed [AXIS_W-1:0] s2_nz [NUM_AXES];

  logic [PROJ_W-1:0]         s3_pa1 [NUM_AXES];
  logic [PROJ_W-1:0]         s3_pa2 [NUM_AXES];
  logic [PROJ_W-1:0]         s3_pb1 [NUM_AXES];
  logic [PROJ_W-1:0]         s3_pb2 [NUM_AXES];
  logic signed [DPROD_W-1:0] s3_dpx [NUM_AXES];
  logic signed [DPROD_W-1:0] s3_dpz [NUM_AXES];
  logic signed [AXIS_W-1:0]  s3_nx [NUM_AXES];
  logic signed [AXIS_W-1:0]  s3_nz [NUM_AXES];

  logic [RAD_W-1:0]         s4_rad [NUM_AXES];
  logic signed [DN_W-1:0]   s4_dn [NUM_AXES];
  logic signed [AXIS_W-1:0] s4_nx [NUM_AXES];
  logic signed [AXIS_W-1:0] s4_nz [NUM_AXES];

  logic signed [OV_W-1:0]   s5_ov [NUM_AXES];
  logic [NUM_AXES-1:0]      s5_neg;
  logic signed [AXIS_W-1:0] s5_nx [NUM_AXES];
  logic signed [AXIS_W-1:0] s5_nz [NUM_AXES];

  logic                     ov_all_pos;
  logic                     s6_hit;
  logic signed [OV_W-1:0]   s6_w01, s6_w23;
  logic                     s6_i01, s6_i23;
  logic [NUM_AXES-1:0]      s6_neg;
  logic signed [AXIS_W-1:0] s6_nx [NUM_AXES];
  logic signed [AXIS_W-1:0] s6_nz [NUM_AXES];

  logic                     s7_hit;
  logic signed [AXIS_W-1:0] s7_nx, s7_nz;
  logic [DEPTH_W-1:0]       s7_depth;

  logic                     hit_next;
  logic                     sel_hi;
  logic [1:0]               win;
  logic signed [OV_W-1:0]   best;
  logic [OV_W-1:0]          rnd;
  logic [OV_W-1:0]          shifted;
  logic signed [AXIS_W-1:0] nx_next, nz_next;
  logic [DEPTH_W-1:0]       depth_next;

  assign in_box.cx  = s_axis_tdata[0 +: COORD_WIDTH];
  assign in_box.cz  = s_axis_tdata[OFF_CZ +: COORD_WIDTH];
  assign in_box.hx  = s_axis_tdata[OFF_HX +: HALF_W];
  assign in_box.hz  = s_axis_tdata[OFF_HZ +: HALF_W];
  assign in_box.a1x = s_axis_tdata[OFF_A1X +: AXIS_W];
  assign in_box.a1z = s_axis_tdata[OFF_A1Z +: AXIS_W];
  assign in_box.a2x = s_axis_tdata[OFF_A2X +: AXIS_W];
  assign in_box.a2z = s_axis_tdata[OFF_A2Z +: AXIS_W];

  always_comb begin
    rdy[NUM_STAGES+1] = m_axis_tready;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[1];
  assign load_acc      = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      v       <= '0;
      ref_box <= '0;
    end else begin
      if (load_acc) begin
        ref_box <= in_box;
      end
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (rdy[k]) begin
          if (k == 1) begin
            v[k] <= s_axis_tvalid && (s_axis_tuser == KIND_TEST);
          end else begin
            v[k] <= v[k-1];
          end
        end
      end
    end
  end

  // stage 1: box b and a snapshot of the reference taken at acceptance
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_a <= ref_box;
      s1_b <= in_box;
    end
  end

  // candidate axes: a's two, then b's two
  always_comb begin
    s1_nx[0] = s1_a.a1x; s1_nz[0] = s1_a.a1z;
    s1_nx[1] = s1_a.a2x; s1_nz[1] = s1_a.a2z;
    s1_nx[2] = s1_b.a1x; s1_nz[2] = s1_b.a1z;
    s1_nx[3] = s1_b.a2x; s1_nz[3] = s1_b.a2z;
  end

  // stage 2: absolute axis dot products, center difference
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s2_ad1[i] <= abs_dot(dot2(s1_a.a1x, s1_a.a1z, s1_nx[i], s1_nz[i]));
        s2_ad2[i] <= abs_dot(dot2(s1_a.a2x, s1_a.a2z, s1_nx[i], s1_nz[i]));
        s2_bd1[i] <= abs_dot(dot2(s1_b.a1x, s1_b.a1z, s1_nx[i], s1_nz[i]));
        s2_bd2[i] <= abs_dot(dot2(s1_b.a2x, s1_b.a2z, s1_nx[i], s1_nz[i]));
        s2_nx[i]  <= s1_nx[i];
        s2_nz[i]  <= s1_nz[i];
      end
      s2_dx  <= DIFF_W'($signed(s1_a.cx)) - DIFF_W'($signed(s1_b.cx));
      s2_dz  <= DIFF_W'($signed(s1_a.cz)) - DIFF_W'($signed(s1_b.cz));
      s2_hax <= s1_a.hx;
      s2_haz <= s1_a.hz;
      s2_hbx <= s1_b.hx;
      s2_hbz <= s1_b.hz;
    end
  end

  // stage 3: projection products
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s3_pa1[i] <= PROJ_W'(s2_hax) * PROJ_W'(s2_ad1[i]);
        s3_pa2[i] <= PROJ_W'(s2_haz) * PROJ_W'(s2_ad2[i]);
        s3_pb1[i] <= PROJ_W'(s2_hbx) * PROJ_W'(s2_bd1[i]);
        s3_pb2[i] <= PROJ_W'(s2_hbz) * PROJ_W'(s2_bd2[i]);
        s3_dpx[i] <= DPROD_W'(s2_dx) * DPROD_W'(s2_nx[i]);
        s3_dpz[i] <= DPROD_W'(s2_dz) * DPROD_W'(s2_nz[i]);
        s3_nx[i]  <= s2_nx[i];
        s3_nz[i]  <= s2_nz[i];
      end
    end
  end

  // stage 4: summed radii and signed center distance along each axis
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s4_rad[i] <= RAD_W'(s3_pa1[i]) + RAD_W'(s3_pa2[i])
                   + RAD_W'(s3_pb1[i]) + RAD_W'(s3_pb2[i]);
        s4_dn[i]  <= DN_W'(s3_dpx[i]) + DN_W'(s3_dpz[i]);
        s4_nx[i]  <= s3_nx[i];
        s4_nz[i]  <= s3_nz[i];
      end
    end
  end

  // stage 5: overlap per axis, distance scaled up to the radius format
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s5_ov[i]  <= $signed(OV_W'(s4_rad[i]))
                   - $signed(OV_W'({abs_dn(s4_dn[i]), {AXIS_FRAC_BITS{1'b0}}}));
        s5_neg[i] <= s4_dn[i][DN_W-1];
        s5_nx[i]  <= s4_nx[i];
        s5_nz[i]  <= s4_nz[i];
      end
    end
  end

  // a zero or negative overlap on any axis separates the boxes
  always_comb begin
    ov_all_pos = 1'b1;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (s5_ov[i][OV_W-1] || (s5_ov[i] == '0)) begin
        ov_all_pos = 1'b0;
      end
    end
  end

  // stage 6: all-positive check and pairwise minimum, earlier axis wins ties
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_hit <= ov_all_pos;
      for (int i = 0; i < NUM_AXES; i++) begin
        s6_nx[i] <= s5_nx[i];
        s6_nz[i] <= s5_nz[i];
      end
      s6_i01 <= (s5_ov[1] < s5_ov[0]);
      s6_w01 <= (s5_ov[1] < s5_ov[0]) ? s5_ov[1] : s5_ov[0];
      s6_i23 <= (s5_ov[3] < s5_ov[2]);
      s6_w23 <= (s5_ov[3] < s5_ov[2]) ? s5_ov[3] : s5_ov[2];
      s6_neg <= s5_neg;
    end
  end

  // stage 7: final pick, normal flip toward a, depth rounding
  always_comb begin
    sel_hi  = (s6_w23 < s6_w01);
    win     = sel_hi ? {1'b1, s6_i23} : {1'b0, s6_i01};
    best    = sel_hi ? s6_w23 : s6_w01;
    rnd     = $unsigned(best) + HALF_LSB;
    shifted = rnd >> FRAC_DROP;
    hit_next = s6_hit;
    if (s6_neg[win]) begin
      nx_next = neg_sat(s6_nx[win]);
      nz_next = neg_sat(s6_nz[win]);
    end else begin
      nx_next = s6_nx[win];
      nz_next = s6_nz[win];
    end
    if (shifted > OV_W'(DEPTH_MAX)) begin
      depth_next = DEPTH_MAX;
    end else begin
      depth_next = shifted[DEPTH_W-1:0];
    end
    if (!s6_hit) begin
      nx_next    = '0;
      nz_next    = '0;
      depth_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_hit   <= hit_next;
      s7_nx    <= nx_next;
      s7_nz    <= nz_next;
      s7_depth <= depth_next;
    end
  end

  assign m_axis_tvalid = v[NUM_STAGES];
  assign m_axis_tuser  = s7_hit;
  assign m_axis_tdata  = OUT_TDATA_W'({s7_depth, s7_nz, s7_nx});

  // a miss carries an all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss with nonzero normal or depth");

  // load items write the reference and never enter the pipeline
  a_load_ref: assert property (@(posedge clk) disable iff (rst)
    load_acc |=> ref_box == $past(in_box))
    else $error("reference not written by load item");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    load_acc |=> !v[1])
    else $error("load item entered the pipeline");

  // a blocked stage 6 keeps its item
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    v[6] && !rdy[7] |=> v[6] && $stable(s6_w01) && $stable(s6_hit))
    else $error("stalled stage lost its item");

endmodule

`default_nettype wire

// ===== verif/obb_contact_monitor.sv =====
// box and contact stream monitor: predicts each contact from the box items and compares
`timescale 1ns / 100ps

module obb_contact_monitor
  import obb_sat_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_axis_tvalid,
  input  wire                   s_axis_tready,
  input  wire [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire                   s_axis_tuser,
  input  wire                   m_axis_tvalid,
  input  wire                   m_axis_tready,
  input  wire [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire                   m_axis_tuser,
  output int                    mismatches,
  output int                    contacts_pending
);

  typedef struct packed {
    logic                     hit;
    logic signed [AXIS_W-1:0] nx;
    logic signed [AXIS_W-1:0] nz;
    logic [DEPTH_W-1:0]       depth;
  } contact_t;

  localparam int CZ_LSB  = COORD_WIDTH;
  localparam int HX_LSB  = 2 * COORD_WIDTH;
  localparam int HZ_LSB  = HX_LSB + HALF_W;
  localparam int A1X_LSB = HZ_LSB + HALF_W;
  localparam int A1Z_LSB = A1X_LSB + AXIS_W;
  localparam int A2X_LSB = A1Z_LSB + AXIS_W;
  localparam int A2Z_LSB = A2X_LSB + AXIS_W;

  localparam longint NORMAL_MAX = (longint'(1) << (AXIS_W - 1)) - 1;
  localparam longint DEPTH_MAX  = (longint'(1) << DEPTH_W) - 1;

  box_t     ref_box;
  contact_t contacts_due[$];
  int       contacts_seen;

  // extent of a box projected on n, Q.44
  function automatic longint proj_radius(box_t bx, longint nx, longint nz);
    longint d1;
    longint d2;
    d1 = longint'($signed(bx.a1x)) * nx + longint'($signed(bx.a1z)) * nz;
    d2 = longint'($signed(bx.a2x)) * nx + longint'($signed(bx.a2z)) * nz;
    if (d1 < 0) d1 = -d1;
    if (d2 < 0) d2 = -d2;
    return longint'(bx.hx) * d1 + longint'(bx.hz) * d2;
  endfunction

  function automatic contact_t predict_contact(box_t a, box_t b);
    longint   nxs [NUM_AXES];
    longint   nzs [NUM_AXES];
    longint   dx;
    longint   dz;
    longint   dn;
    longint   ov;
    longint   best;
    longint   nx;
    longint   nz;
    longint   depth_q16;
    int       win;
    int       i;
    contact_t res;
    res = '0;
    nxs[0] = longint'($signed(a.a1x));
    nzs[0] = longint'($signed(a.a1z));
    nxs[1] = longint'($signed(a.a2x));
    nzs[1] = longint'($signed(a.a2z));
    nxs[2] = longint'($signed(b.a1x));
    nzs[2] = longint'($signed(b.a1z));
    nxs[3] = longint'($signed(b.a2x));
    nzs[3] = longint'($signed(b.a2z));
    dx = longint'($signed(a.cx)) - longint'($signed(b.cx));
    dz = longint'($signed(a.cz)) - longint'($signed(b.cz));
    win = -1;
    best = 0;
    for (i = 0; i < NUM_AXES; i++) begin
      dn = dx * nxs[i] + dz * nzs[i];
      if (dn < 0) dn = -dn;
      ov = proj_radius(a, nxs[i], nzs[i]) + proj_radius(b, nxs[i], nzs[i])
           - (dn <<< AXIS_FRAC_BITS);
      // separating axis found: miss reports all zeros
      if (ov <= 0) return res;
      if (win < 0 || ov < best) begin
        best = ov;
        win = i;
      end
    end
    nx = nxs[win];
    nz = nzs[win];
    // normal points from b toward a
    if (dx * nx + dz * nz < 0) begin
      nx = -nx;
      nz = -nz;
      if (nx > NORMAL_MAX) nx = NORMAL_MAX;
      if (nz > NORMAL_MAX) nz = NORMAL_MAX;
    end
    depth_q16 = (best + (longint'(1) << (FRAC_DROP - 1))) >>> FRAC_DROP;
    if (depth_q16 > DEPTH_MAX) depth_q16 = DEPTH_MAX;
    res.hit   = 1'b1;
    res.nx    = nx[AXIS_W-1:0];
    res.nz    = nz[AXIS_W-1:0];
    res.depth = depth_q16[DEPTH_W-1:0];
    return res;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    box_t     box_in;
    contact_t got;
    contact_t want;
    if (rst) begin
      ref_box = '0;
      contacts_due.delete();
      contacts_seen = 0;
      mismatches = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit   = m_axis_tuser;
        got.nx    = m_axis_tdata[0 +: AXIS_W];
        got.nz    = m_axis_tdata[AXIS_W +: AXIS_W];
        got.depth = m_axis_tdata[2*AXIS_W +: DEPTH_W];
        if (contacts_due.size() == 0) begin
          note_mismatch($sformatf("contact %0d arrived with none due: hit %0d nx %0d nz %0d depth %0d",
                                  contacts_seen, got.hit, got.nx, got.nz, got.depth));
        end else begin
          want = contacts_due.pop_front();
          if (got.hit !== want.hit)
            note_mismatch($sformatf("contact %0d hit: expected %0d, got %0d",
                                    contacts_seen, want.hit, got.hit));
          if (got.nx !== want.nx)
            note_mismatch($sformatf("contact %0d normal_x: expected %0d, got %0d",
                                    contacts_seen, want.nx, got.nx));
          if (got.nz !== want.nz)
            note_mismatch($sformatf("contact %0d normal_z: expected %0d, got %0d",
                                    contacts_seen, want.nz, got.nz));
          if (got.depth !== want.depth)
            note_mismatch($sformatf("contact %0d depth: expected %0d, got %0d",
                                    contacts_seen, want.depth, got.depth));
        end
        contacts_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        box_in.cx  = s_axis_tdata[0 +: COORD_WIDTH];
        box_in.cz  = s_axis_tdata[CZ_LSB +: COORD_WIDTH];
        box_in.hx  = s_axis_tdata[HX_LSB +: HALF_W];
        box_in.hz  = s_axis_tdata[HZ_LSB +: HALF_W];
        box_in.a1x = s_axis_tdata[A1X_LSB +: AXIS_W];
        box_in.a1z = s_axis_tdata[A1Z_LSB +: AXIS_W];
        box_in.a2x = s_axis_tdata[A2X_LSB +: AXIS_W];
        box_in.a2z = s_axis_tdata[A2Z_LSB +: AXIS_W];
        if (kind_t'(s_axis_tuser) == KIND_LOAD) begin
          ref_box = box_in;
        end else begin
          contacts_due.push_back(predict_contact(ref_box, box_in));
        end
      end
    end
    contacts_pending = contacts_due.size();
  end

endmodule

// ===== verif/tb_obb_2d_sat_overlap.sv =====
// stimulus, handshake pacing and verdict for the oriented box overlap test
`timescale 1ns / 100ps

module tb_obb_2d_sat_overlap;
  import obb_sat_pkg::*;

  localparam int LATENCY   = 7;
  localparam int LONG_HOLD = 300;
  localparam int UNIT      = 65536;   // 1.0 in Q16
  localparam int NEAR      = 393216;  // test boxes land within 6 units of the reference

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  wire                    s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  wire                    m_axis_tvalid;
  logic                   m_axis_tready;
  wire  [OUT_TDATA_W-1:0] m_axis_tdata;
  wire                    m_axis_tuser;

  int   mismatches;
  int   contacts_pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   holds_asked;
  int   holds_done;
  box_t sketch;

  obb_2d_sat_overlap DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  obb_contact_monitor contact_watch (
    .clk              (clk),
    .rst              (rst),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .mismatches       (mismatches),
    .contacts_pending (contacts_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // orthonormal axis pair for one of 16 directions: 0/30/45/60 degrees in each quadrant
  function automatic box_t orient(box_t bx, int dir);
    int c;
    int s;
    int t;
    case (dir % 4)
      0: begin
        c = 16384;
        s = 0;
      end
      1: begin
        c = 14189;
        s = 8192;
      end
      2: begin
        c = 11585;
        s = 11585;
      end
      default: begin
        c = 8192;
        s = 14189;
      end
    endcase
    repeat ((dir / 4) % 4) begin
      t = c;
      c = -s;
      s = t;
    end
    bx.a1x = AXIS_W'(c);
    bx.a1z = AXIS_W'(s);
    bx.a2x = AXIS_W'(-s);
    bx.a2z = AXIS_W'(c);
    return bx;
  endfunction

  function automatic box_t make_box(longint cx, longint cz, longint hx, longint hz, int dir);
    box_t bx;
    bx.cx = COORD_WIDTH'(cx);
    bx.cz = COORD_WIDTH'(cz);
    bx.hx = HALF_W'(hx);
    bx.hz = HALF_W'(hz);
    return orient(bx, dir);
  endfunction

  function automatic box_t with_axes(box_t bx, int ux, int uz, int vx, int vz);
    bx.a1x = AXIS_W'(ux);
    bx.a1z = AXIS_W'(uz);
    bx.a2x = AXIS_W'(vx);
    bx.a2z = AXIS_W'(vz);
    return bx;
  endfunction

  // called and returns at a falling edge; the item stays offered until accepted
  task automatic send_box(kind_t kind, box_t bx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= IN_TDATA_W'({bx.a2z, bx.a2x, bx.a1z, bx.a1x, bx.hz, bx.hx, bx.cz, bx.cx});
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (contacts_pending != 0);
  endtask

  // mostly a reference followed by tests around it, with some raw noise items
  task automatic send_random(int count);
    box_t bx;
    int   pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        sketch = make_box(int'($urandom_range(0, 1 << 25)) - (1 << 24),
                          int'($urandom_range(0, 1 << 25)) - (1 << 24),
                          $urandom_range(16384, 262144), $urandom_range(16384, 262144),
                          $urandom_range(15));
        send_box(KIND_LOAD, sketch);
      end else if (pick < 85) begin
        bx = make_box(longint'($signed(sketch.cx)) + int'($urandom_range(0, 2 * NEAR)) - NEAR,
                      longint'($signed(sketch.cz)) + int'($urandom_range(0, 2 * NEAR)) - NEAR,
                      $urandom_range(16384, 262144), $urandom_range(16384, 262144),
                      $urandom_range(15));
        send_box(KIND_TEST, bx);
      end else begin
        bx = IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        send_box(kind_t'($urandom_range(1)), bx);
      end
    end
  endtask

  initial begin
    int hold_left;
    m_axis_tready = 1'b1;
    holds_done = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holds_asked = 0;
    sketch = make_box(0, 0, UNIT, UNIT, 0);
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero reference after reset: the test before the first load misses
    send_box(KIND_TEST, make_box(0, 0, UNIT, UNIT, 0));
    send_box(KIND_LOAD, make_box(0, 0, UNIT, UNIT, 0));
    send_box(KIND_TEST, make_box(UNIT + UNIT / 2, 0, UNIT, UNIT, 0));
    send_box(KIND_TEST, make_box(-(UNIT + UNIT / 2), UNIT / 4, UNIT, UNIT, 0));
    // touching edges give zero overlap
    send_box(KIND_TEST, make_box(2 * UNIT, 0, UNIT, UNIT, 0));
    send_box(KIND_TEST, make_box(0, -(UNIT + 3 * UNIT / 4), UNIT, UNIT, 2));
    send_box(KIND_TEST, make_box(2 * UNIT - 1, 0, UNIT, UNIT, 0));
    send_box(KIND_TEST, make_box(0, 5 * UNIT, UNIT, UNIT, 9));
    // tiny axes: a hit whose depth rounds to zero
    send_box(KIND_LOAD, with_axes(make_box(0, 0, 1, 1, 0), 1, 0, 0, 1));
    send_box(KIND_TEST, with_axes(make_box(0, 0, 1, 1, 0), 1, 0, 0, 1));
    // most negative axis code on the winning axis, flipped normal saturates
    send_box(KIND_LOAD, with_axes(make_box(UNIT / 2, 0, UNIT, UNIT, 0), -32768, 0, 0, -32768));
    send_box(KIND_TEST, with_axes(make_box(0, 0, UNIT, UNIT, 0), -32768, 0, 0, -32768));
    // largest halves and axes: depth saturates
    send_box(KIND_LOAD, with_axes(make_box(0, 0, 'hFF_FFFF, 'hFF_FFFF, 0),
                                  32767, 32767, 32767, 32767));
    send_box(KIND_TEST, with_axes(make_box(0, 0, 'hFF_FFFF, 'hFF_FFFF, 0),
                                  32767, 32767, 32767, 32767));
    send_box(KIND_TEST, make_box('h7FFF_FFFF, 'h7FFF_FFFF, UNIT, UNIT, 0));
    // centers at both ends of the coordinate range
    send_box(KIND_LOAD, make_box('h8000_0000, 'h8000_0000, UNIT, UNIT, 0));
    send_box(KIND_TEST, make_box('h7FFF_FFFF, 'h7FFF_FFFF, UNIT, UNIT, 0));
    send_box(KIND_TEST, make_box('h8000_0000, 'h8000_0000, UNIT, UNIT, 0));
    // zero size boxes never overlap
    send_box(KIND_LOAD, make_box(0, 0, 0, 0, 0));
    send_box(KIND_TEST, make_box(0, 0, 0, 0, 0));
    send_box(KIND_LOAD, make_box(0, 0, UNIT, 2 * UNIT, 0));
    send_box(KIND_TEST, make_box(UNIT / 3, -UNIT, UNIT, UNIT / 2, 5));
    send_box(KIND_TEST, make_box(-UNIT, UNIT / 5, 3 * UNIT, UNIT / 4, 14));
    drain();

    // full rate, with the output held off long enough for the pipeline to back up
    holds_asked++;
    send_random(40);
    send_random(150);
    drain();

    send_idle_pct = 67;
    recv_stall_pct = 0;
    send_random(185);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 67;
    send_random(185);
    drain();

    send_idle_pct = 25;
    recv_stall_pct = 25;
    send_random(185);
    drain();

    repeat (4 * LATENCY) @(negedge clk);
    if (mismatches == 0 && contacts_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
